>>> rtl/core/lsa_pkg.sv
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared types, widths and helper functions of the lane segment averager.
// ----------------------------------------------------------------------------
package lsa_pkg;

  localparam int DEF_COORD_BITS   = 12;
  localparam int DEF_MAX_SEGMENTS = 256;
  localparam int DEF_FRAC_BITS    = 16;

  localparam int SLOPE_W = 48;
  localparam int ICPT_W  = 56;
  localparam int NUM_W   = ICPT_W;
  localparam int DEN_W   = SLOPE_W;
  localparam int IT_W    = $clog2(NUM_W + 1);
  localparam int XN_W    = ICPT_W + 2;

  localparam logic [11:0] HEIGHT_RST     = 12'd720;
  localparam logic        CFG_IDX_HEIGHT = 1'b0;

  typedef struct packed {
    logic [11:0] x_start;
    logic [11:0] y_start;
    logic [11:0] x_end;
    logic [11:0] y_end;
    logic        last_segment;
  } in_word_t;

  typedef struct packed {
    logic               side;
    logic signed [15:0] x_bottom;
    logic [11:0]        y_bottom;
    logic signed [15:0] x_top;
    logic [11:0]        y_top;
    logic               line_valid;
    logic               segments_dropped;
    logic               last_line;
  } out_word_t;

  typedef enum logic [2:0] {
    OP_SEG = 3'd0,
    OP_M   = 3'd1,
    OP_B   = 3'd2,
    OP_XB  = 3'd3,
    OP_XT  = 3'd4
  } div_op_t;

  typedef struct packed {
    logic    load_in;
    logic    div_go;
    div_op_t div_op;
    logic    set_drop;
    logic    load_vert;
    logic    mul;
    logic    acc;
    logic    side;
    logic    emit;
    logic    clear;
  } cmd_t;

  typedef struct packed {
    logic zero_len;
    logic full;
    logic dx_zero;
    logic last;
    logic div_done;
    logic cnt_zero;
    logic mavg_zero;
  } stat_t;

  // floor(v*3/5) by reciprocal, exact for 12-bit v
  function automatic logic [11:0] div5x3(input logic [11:0] v);
    logic [13:0] t;
    logic [27:0] p;
    t = 14'(v) * 14'd3;
    p = 28'(t) * 28'd13108;
    return p[27:16];
  endfunction

  function automatic logic signed [15:0] sat16(input logic neg,
                                               input logic [NUM_W:0] magp);
    logic [15:0] r;
    if (!neg) begin
      r = (magp > (NUM_W+1)'(32767)) ? 16'h7fff : magp[15:0];
    end else begin
      r = (magp > (NUM_W+1)'(32768)) ? 16'h8000 : (16'h0 - magp[15:0]);
    end
    return signed'(r);
  endfunction

endpackage

>>> rtl/core/lane_segment_averager_unit.sv
// ----------------------------------------------------------------------------
// lane_segment_averager_unit
// Averages Hough segments into one left and one right lane line per frame.
// ----------------------------------------------------------------------------
// Input: a segment word is taken when start is high and busy is low. busy
// stays high until the segment is checked and, unless dropped or zero length,
// folded into the side sums, and on a word flagged last_segment until the
// right line has been issued. A dropped or zero-length word is not summed, a
// vertical one skips the bit-serial slope division and any other waits for
// it; a new word is taken only once busy is low again.
// On a word flagged last_segment, each side then runs up to four divisions
// (slope avg 48 steps, intercept avg 56, two end points 56 each) through the
// same divider.
// Output: out_valid strobes for one cycle per line, left then right; the
// receiver cannot stall and must take each word in that cycle.
// Config: image_height over the APB port at address 0; the user must write it
// only while idle, which the block itself does not enforce. Reset clears
// sums, counts, drop flag and sets image_height to 720.
// ----------------------------------------------------------------------------
module lane_segment_averager_unit #(
  parameter int COORD_BITS   = lsa_pkg::DEF_COORD_BITS,
  parameter int MAX_SEGMENTS = lsa_pkg::DEF_MAX_SEGMENTS,
  parameter int FRAC_BITS    = lsa_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lsa_pkg::in_word_t  in_word,
  output logic               out_valid,
  output lsa_pkg::out_word_t out_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [11:0]    image_height_r;
  lsa_pkg::cmd_t  cmd;
  lsa_pkg::stat_t stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == lsa_pkg::CFG_IDX_HEIGHT) ? {20'd0, image_height_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_height_r <= lsa_pkg::HEIGHT_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == lsa_pkg::CFG_IDX_HEIGHT) begin
      image_height_r <= pwdata[11:0];
    end
  end

  lsa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  lsa_dp #(
    .COORD_BITS   (COORD_BITS),
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_word      (in_word),
    .image_height (image_height_r),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_word     (out_word)
  );

endmodule

>>> rtl/core/lsa_div.sv
// ----------------------------------------------------------------------------
// lsa_div
// Restoring unsigned divider, one quotient bit per cycle. The numerator is
// left aligned; iters sets how many of its top bits are processed.
// ----------------------------------------------------------------------------
module lsa_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [lsa_pkg::NUM_W-1:0] num,
  input  logic [lsa_pkg::DEN_W-1:0] den,
  input  logic [lsa_pkg::IT_W-1:0]  iters,
  output logic                      done,
  output logic [lsa_pkg::NUM_W-1:0] quot,
  output logic                      rem_nz
);

  logic [lsa_pkg::NUM_W-1:0] num_r, quot_r;
  logic [lsa_pkg::DEN_W-1:0] den_r, rem_r, rem_nxt;
  logic [lsa_pkg::IT_W-1:0]  cnt_r;
  logic                      run_r, done_r;
  logic [lsa_pkg::DEN_W:0]   shl;
  logic                      ge;

  assign shl     = {rem_r, num_r[lsa_pkg::NUM_W-1]};
  assign ge      = shl >= {1'b0, den_r};
  assign rem_nxt = ge ? lsa_pkg::DEN_W'(shl - {1'b0, den_r}) : shl[lsa_pkg::DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= iters;
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == lsa_pkg::IT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      num_r  <= num;
      den_r  <= den;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (run_r) begin
      num_r  <= {num_r[lsa_pkg::NUM_W-2:0], 1'b0};
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[lsa_pkg::NUM_W-2:0], ge};
    end
  end

  assign done   = done_r;
  assign quot   = quot_r;
  assign rem_nz = rem_r != '0;

endmodule

>>> rtl/core/lsa_ctrl.sv
// ----------------------------------------------------------------------------
// lsa_ctrl
// Sequencer: segment slope/intercept, then per-side averaging and emission.
// ----------------------------------------------------------------------------
module lsa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  lsa_pkg::stat_t  stat,
  output lsa_pkg::cmd_t   cmd
);

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_CHECK   = 14'b00000000000010,
    S_DIV_SEG = 14'b00000000000100,
    S_MUL     = 14'b00000000001000,
    S_ACC     = 14'b00000000010000,
    S_SIDE    = 14'b00000000100000,
    S_DIV_M   = 14'b00000001000000,
    S_CHK_M   = 14'b00000010000000,
    S_DIV_B   = 14'b00000100000000,
    S_LD_XB   = 14'b00001000000000,
    S_DIV_XB  = 14'b00010000000000,
    S_LD_XT   = 14'b00100000000000,
    S_DIV_XT  = 14'b01000000000000,
    S_EMIT    = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   side_r, side_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      side_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      side_r  <= side_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    side_nxt  = side_r;
    cmd       = '0;
    cmd.side  = side_r;
    cmd.div_op = lsa_pkg::OP_SEG;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.zero_len) begin
          state_nxt = stat.last ? S_SIDE : S_IDLE;
        end else if (stat.full) begin
          cmd.set_drop = 1'b1;
          state_nxt    = stat.last ? S_SIDE : S_IDLE;
        end else if (stat.dx_zero) begin
          cmd.load_vert = 1'b1;
          state_nxt     = S_MUL;
        end else begin
          cmd.div_go = 1'b1;
          state_nxt  = S_DIV_SEG;
        end
      end
      S_DIV_SEG: begin
        if (stat.div_done) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = stat.last ? S_SIDE : S_IDLE;
      end
      S_SIDE: begin
        if (stat.cnt_zero) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.div_go = 1'b1;
          cmd.div_op = lsa_pkg::OP_M;
          state_nxt  = S_DIV_M;
        end
      end
      S_DIV_M: begin
        if (stat.div_done) state_nxt = S_CHK_M;
      end
      S_CHK_M: begin
        if (stat.mavg_zero) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.div_go = 1'b1;
          cmd.div_op = lsa_pkg::OP_B;
          state_nxt  = S_DIV_B;
        end
      end
      S_DIV_B: begin
        if (stat.div_done) state_nxt = S_LD_XB;
      end
      S_LD_XB: begin
        cmd.div_go = 1'b1;
        cmd.div_op = lsa_pkg::OP_XB;
        state_nxt  = S_DIV_XB;
      end
      S_DIV_XB: begin
        if (stat.div_done) state_nxt = S_LD_XT;
      end
      S_LD_XT: begin
        cmd.div_go = 1'b1;
        cmd.div_op = lsa_pkg::OP_XT;
        state_nxt  = S_DIV_XT;
      end
      S_DIV_XT: begin
        if (stat.div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (!side_r) begin
          side_nxt  = 1'b1;
          state_nxt = S_SIDE;
        end else begin
          cmd.clear = 1'b1;
          side_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        side_nxt  = 1'b0;
      end
    endcase
  end

  assign busy = state_r != S_IDLE;

endmodule

>>> rtl/core/lsa_dp.sv
// ----------------------------------------------------------------------------
// lsa_dp
// Datapath: segment registers, slope/intercept, side sums, averaging and
// line end points, with the shared divider and the output register.
// ----------------------------------------------------------------------------
module lsa_dp #(
  parameter int COORD_BITS   = lsa_pkg::DEF_COORD_BITS,
  parameter int MAX_SEGMENTS = lsa_pkg::DEF_MAX_SEGMENTS,
  parameter int FRAC_BITS    = lsa_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lsa_pkg::in_word_t  in_word,
  input  logic [11:0]        image_height,
  input  lsa_pkg::cmd_t      cmd,
  output lsa_pkg::stat_t     stat,
  output logic               out_valid,
  output lsa_pkg::out_word_t out_word
);

  localparam int C     = COORD_BITS;
  localparam int MW    = COORD_BITS + FRAC_BITS + 1;
  localparam int PW    = MW + COORD_BITS + 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int SW    = lsa_pkg::SLOPE_W;
  localparam int BW    = lsa_pkg::ICPT_W;
  localparam int NW    = lsa_pkg::NUM_W;
  localparam int DW    = lsa_pkg::DEN_W;
  localparam int XW    = lsa_pkg::XN_W;

  logic [C-1:0]        x1_r, y1_r;
  logic signed [C:0]   dx_r, dy_r;
  logic                last_r;
  logic signed [MW-1:0] slope_r;
  logic signed [PW-1:0] prod_r;
  logic signed [SW-1:0] lsum_r, rsum_r, mavg_r;
  logic signed [BW-1:0] lbsum_r, rbsum_r, bavg_r;
  logic [CNT_W-1:0]    lcnt_r, rcnt_r;
  logic                drop_r;
  logic signed [15:0]  xb_r, xt_r;
  lsa_pkg::div_op_t    op_r;
  logic                out_valid_r;
  lsa_pkg::out_word_t  out_word_r, out_word_nxt;

  logic signed [SW-1:0] ssel;
  logic signed [BW-1:0] bsel;
  logic [CNT_W-1:0]     csel;
  logic [11:0]          y_top;
  logic signed [XW-1:0] xn_b, xn_t, xn_sel;
  logic [C-1:0]         dx_mag, dy_mag;
  logic [SW-1:0]        s_mag, m_mag;
  logic [BW-1:0]        b_mag;
  logic [NW-1:0]        xn_mag, div_num;
  logic [DW-1:0]        div_den;
  logic [lsa_pkg::IT_W-1:0] div_it;
  logic                 div_done, div_rnz;
  logic [NW-1:0]        div_q;
  logic                 seg_neg, x_neg;
  logic [BW-1:0]        b_seg;
  logic [NW:0]          x_magp;

  assign ssel  = cmd.side ? rsum_r  : lsum_r;
  assign bsel  = cmd.side ? rbsum_r : lbsum_r;
  assign csel  = cmd.side ? rcnt_r  : lcnt_r;
  assign y_top = lsa_pkg::div5x3(image_height);

  assign dx_mag = C'(dx_r[C] ? -dx_r : dx_r);
  assign dy_mag = C'(dy_r[C] ? -dy_r : dy_r);
  assign s_mag  = ssel[SW-1] ? SW'(-ssel) : SW'(ssel);
  assign b_mag  = bsel[BW-1] ? BW'(-bsel) : BW'(bsel);
  assign m_mag  = mavg_r[SW-1] ? SW'(-mavg_r) : SW'(mavg_r);

  assign xn_b   = (XW'(image_height) <<< FRAC_BITS) - XW'(bavg_r);
  assign xn_t   = (XW'(y_top) <<< FRAC_BITS) - XW'(bavg_r);
  assign xn_sel = (op_r == lsa_pkg::OP_XT || cmd.div_op == lsa_pkg::OP_XT) ? xn_t : xn_b;
  assign xn_mag = NW'(xn_sel[XW-1] ? -xn_sel : xn_sel);

  assign seg_neg = dy_r[C] ^ dx_r[C];
  assign x_neg   = xn_sel[XW-1] ^ mavg_r[SW-1];
  assign x_magp  = {1'b0, div_q} + (NW+1)'(x_neg & div_rnz);

  always_comb begin
    div_num = '0;
    div_den = '0;
    div_it  = '0;
    case (cmd.div_op)
      lsa_pkg::OP_SEG: begin
        div_num = (NW'(dy_mag) << FRAC_BITS) << (NW - C - FRAC_BITS);
        div_den = DW'(dx_mag);
        div_it  = lsa_pkg::IT_W'(C + FRAC_BITS);
      end
      lsa_pkg::OP_M: begin
        div_num = NW'(s_mag) << (NW - SW);
        div_den = DW'(csel);
        div_it  = lsa_pkg::IT_W'(SW);
      end
      lsa_pkg::OP_B: begin
        div_num = NW'(b_mag);
        div_den = DW'(csel);
        div_it  = lsa_pkg::IT_W'(NW);
      end
      lsa_pkg::OP_XB, lsa_pkg::OP_XT: begin
        div_num = xn_mag;
        div_den = m_mag;
        div_it  = lsa_pkg::IT_W'(NW);
      end
      default: begin
        div_num = '0;
      end
    endcase
  end

  lsa_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (cmd.div_go),
    .num    (div_num),
    .den    (div_den),
    .iters  (div_it),
    .done   (div_done),
    .quot   (div_q),
    .rem_nz (div_rnz)
  );

  assign b_seg = (BW'(y1_r) << FRAC_BITS) - BW'(prod_r);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x1_r   <= C'(in_word.x_start);
      y1_r   <= C'(in_word.y_start);
      dx_r   <= signed'({1'b0, C'(in_word.x_end)}) - signed'({1'b0, C'(in_word.x_start)});
      dy_r   <= signed'({1'b0, C'(in_word.y_end)}) - signed'({1'b0, C'(in_word.y_start)});
      last_r <= in_word.last_segment;
    end
    if (cmd.div_go) op_r <= cmd.div_op;
    if (cmd.load_vert) begin
      slope_r <= signed'({1'b0, {(MW-1){1'b1}}});
    end
    if (cmd.mul) prod_r <= slope_r * signed'({1'b0, x1_r});
    if (div_done) begin
      case (op_r)
        lsa_pkg::OP_SEG: slope_r <= seg_neg ? -signed'(MW'(div_q)) : signed'(MW'(div_q));
        lsa_pkg::OP_M:   mavg_r  <= ssel[SW-1] ? -signed'(SW'(div_q)) : signed'(SW'(div_q));
        lsa_pkg::OP_B:   bavg_r  <= bsel[BW-1] ? -signed'(BW'(div_q)) : signed'(BW'(div_q));
        lsa_pkg::OP_XB:  xb_r    <= lsa_pkg::sat16(x_neg, x_magp);
        lsa_pkg::OP_XT:  xt_r    <= lsa_pkg::sat16(x_neg, x_magp);
        default:         xt_r    <= xt_r;
      endcase
    end
    out_word_r <= cmd.emit ? out_word_nxt : out_word_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      lsum_r  <= '0;
      rsum_r  <= '0;
      lbsum_r <= '0;
      rbsum_r <= '0;
      lcnt_r  <= '0;
      rcnt_r  <= '0;
      drop_r  <= 1'b0;
    end else begin
      if (cmd.set_drop) drop_r <= 1'b1;
      if (cmd.acc) begin
        if (slope_r[MW-1]) begin
          lsum_r  <= lsum_r + SW'(slope_r);
          lbsum_r <= lbsum_r + b_seg;
          lcnt_r  <= lcnt_r + 1'b1;
        end else begin
          rsum_r  <= rsum_r + SW'(slope_r);
          rbsum_r <= rbsum_r + b_seg;
          rcnt_r  <= rcnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.emit;
  end

  always_comb begin
    out_word_nxt.side             = cmd.side;
    out_word_nxt.line_valid       = !stat.cnt_zero && !stat.mavg_zero;
    out_word_nxt.x_bottom         = out_word_nxt.line_valid ? xb_r : 16'sd0;
    out_word_nxt.y_bottom         = image_height;
    out_word_nxt.x_top            = out_word_nxt.line_valid ? xt_r : 16'sd0;
    out_word_nxt.y_top            = y_top;
    out_word_nxt.segments_dropped = drop_r;
    out_word_nxt.last_line        = cmd.side;
  end

  assign stat.zero_len  = (dx_r == '0) && (dy_r == '0);
  assign stat.full      = ((CNT_W+1)'(lcnt_r) + (CNT_W+1)'(rcnt_r)) >= (CNT_W+1)'(MAX_SEGMENTS);
  assign stat.dx_zero   = dx_r == '0;
  assign stat.last      = last_r;
  assign stat.div_done  = div_done;
  assign stat.cnt_zero  = csel == '0;
  assign stat.mavg_zero = mavg_r == '0;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> rtl/core/lsa_chk.sv
// ----------------------------------------------------------------------------
// lsa_chk
// Port-level checks of the lane segment averager, bound to the top level.
// ----------------------------------------------------------------------------
module lsa_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input lsa_pkg::out_word_t out_word
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  a_left_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.last_line |=> !out_valid)
    else $error("right line right after left line");

  a_side_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.side == out_word.last_line)
    else $error("side and last_line disagree");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.line_valid |-> out_word.x_bottom == 16'sd0 &&
                                          out_word.x_top == 16'sd0)
    else $error("invalid line with nonzero x");

endmodule

bind lane_segment_averager_unit lsa_chk u_lsa_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_word  (out_word)
);
